// File: hdl/vtps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared widths, register indexes and the sideband record of the divider.
// ----------------------------------------------------------------------------
package vtps_pkg;

  localparam int COORD_W  = 13;
  localparam int NORMAL_W = 12;
  localparam int COEF_W   = 10;
  localparam int ROW_W    = 30;
  localparam int OFFS_W   = 21;
  localparam int CENTER_W = 22;
  localparam int HALF_W   = 11;
  localparam int POS_W    = 24;
  localparam int NRM_W    = 23;
  localparam int SHADE_W  = 8;
  localparam int SCREEN_W = 32;
  localparam int CFG_W    = 30;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X    = 3'd0,
    REG_ROW_Y    = 3'd1,
    REG_ROW_Z    = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5,
    REG_CENTER   = 3'd6,
    REG_LIGHT    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                     proj;
    logic signed [POS_W-1:0]  depth;
    logic [SHADE_W-1:0]       shade;
    logic                     last;
    logic                     neg_x;
    logic                     neg_y;
  } side_t;

endpackage

// File: hdl/vtps_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex transform stages
// Multiplies the vertex by the matrix and the normal by its z row, then sums and translates.
// ----------------------------------------------------------------------------
module vtps_xform (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 valid_in,
  input  logic signed [vtps_pkg::COORD_W-1:0]  cx,
  input  logic signed [vtps_pkg::COORD_W-1:0]  cy,
  input  logic signed [vtps_pkg::COORD_W-1:0]  cz,
  input  logic signed [vtps_pkg::NORMAL_W-1:0] nx,
  input  logic signed [vtps_pkg::NORMAL_W-1:0] ny,
  input  logic signed [vtps_pkg::NORMAL_W-1:0] nz,
  input  logic                                 last_in,
  input  logic [vtps_pkg::ROW_W-1:0]           row_x,
  input  logic [vtps_pkg::ROW_W-1:0]           row_y,
  input  logic [vtps_pkg::ROW_W-1:0]           row_z,
  input  logic signed [vtps_pkg::OFFS_W-1:0]   off_x,
  input  logic signed [vtps_pkg::OFFS_W-1:0]   off_y,
  input  logic signed [vtps_pkg::OFFS_W-1:0]   off_z,
  output logic                                 valid_out,
  output logic signed [vtps_pkg::POS_W-1:0]    rx,
  output logic signed [vtps_pkg::POS_W-1:0]    ry,
  output logic signed [vtps_pkg::POS_W-1:0]    rz,
  output logic signed [vtps_pkg::NRM_W-1:0]    rnz,
  output logic                                 last_out
);

  localparam int PW = vtps_pkg::COORD_W + vtps_pkg::COEF_W;
  localparam int NW = vtps_pkg::NORMAL_W + vtps_pkg::COEF_W;

  logic signed [PW-1:0] px [3];
  logic signed [PW-1:0] py [3];
  logic signed [PW-1:0] pz [3];
  logic signed [NW-1:0] pn [3];
  logic                 v1;
  logic                 last1;

  function automatic logic signed [vtps_pkg::COEF_W-1:0] coef(
    input logic [vtps_pkg::ROW_W-1:0] row, input int k);
    coef = $signed(row[k*vtps_pkg::COEF_W +: vtps_pkg::COEF_W]);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
      valid_out <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px[0] <= PW'(cx) * PW'(coef(row_x, 0));
      px[1] <= PW'(cy) * PW'(coef(row_x, 1));
      px[2] <= PW'(cz) * PW'(coef(row_x, 2));
      py[0] <= PW'(cx) * PW'(coef(row_y, 0));
      py[1] <= PW'(cy) * PW'(coef(row_y, 1));
      py[2] <= PW'(cz) * PW'(coef(row_y, 2));
      pz[0] <= PW'(cx) * PW'(coef(row_z, 0));
      pz[1] <= PW'(cy) * PW'(coef(row_z, 1));
      pz[2] <= PW'(cz) * PW'(coef(row_z, 2));
      pn[0] <= NW'(nx) * NW'(coef(row_z, 0));
      pn[1] <= NW'(ny) * NW'(coef(row_z, 1));
      pn[2] <= NW'(nz) * NW'(coef(row_z, 2));
      last1 <= last_in;
      rx <= vtps_pkg::POS_W'(px[0]) + vtps_pkg::POS_W'(px[1])
          + vtps_pkg::POS_W'(px[2]) + vtps_pkg::POS_W'(off_x);
      ry <= vtps_pkg::POS_W'(py[0]) + vtps_pkg::POS_W'(py[1])
          + vtps_pkg::POS_W'(py[2]) + vtps_pkg::POS_W'(off_y);
      rz <= vtps_pkg::POS_W'(pz[0]) + vtps_pkg::POS_W'(pz[1])
          + vtps_pkg::POS_W'(pz[2]) + vtps_pkg::POS_W'(off_z);
      rnz <= vtps_pkg::NRM_W'(pn[0]) + vtps_pkg::NRM_W'(pn[1])
           + vtps_pkg::NRM_W'(pn[2]);
      last_out <= last1;
    end
  end

endmodule

// File: hdl/vtps_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider step
// One restoring step that yields one quotient bit for both screen axes.
// ----------------------------------------------------------------------------
module vtps_div_step #(
  parameter int NUM_W = 32,
  parameter int STEP  = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             valid_in,
  input  logic [vtps_pkg::POS_W-1:0]       divisor_in,
  input  logic [NUM_W-1:0]                 num_x_in,
  input  logic [NUM_W-1:0]                 num_y_in,
  input  logic [vtps_pkg::POS_W-1:0]       rem_x_in,
  input  logic [vtps_pkg::POS_W-1:0]       rem_y_in,
  input  logic [NUM_W-1:0]                 quo_x_in,
  input  logic [NUM_W-1:0]                 quo_y_in,
  input  vtps_pkg::side_t                  side_in,
  output logic                             valid_out,
  output logic [vtps_pkg::POS_W-1:0]       divisor_out,
  output logic [NUM_W-1:0]                 num_x_out,
  output logic [NUM_W-1:0]                 num_y_out,
  output logic [vtps_pkg::POS_W-1:0]       rem_x_out,
  output logic [vtps_pkg::POS_W-1:0]       rem_y_out,
  output logic [NUM_W-1:0]                 quo_x_out,
  output logic [NUM_W-1:0]                 quo_y_out,
  output vtps_pkg::side_t                  side_out
);

  localparam int RW  = vtps_pkg::POS_W;
  localparam int BIT = NUM_W - 1 - STEP;

  logic [RW-1:0] sh_x;
  logic [RW-1:0] sh_y;
  logic          ge_x;
  logic          ge_y;

  assign sh_x = {rem_x_in[RW-2:0], num_x_in[BIT]};
  assign sh_y = {rem_y_in[RW-2:0], num_y_in[BIT]};
  assign ge_x = sh_x >= divisor_in;
  assign ge_y = sh_y >= divisor_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      divisor_out <= divisor_in;
      num_x_out <= num_x_in;
      num_y_out <= num_y_in;
      rem_x_out <= ge_x ? sh_x - divisor_in : sh_x;
      rem_y_out <= ge_y ? sh_y - divisor_in : sh_y;
      quo_x_out <= {quo_x_in[NUM_W-2:0], ge_x};
      quo_y_out <= {quo_y_in[NUM_W-2:0], ge_y};
      side_out <= side_in;
    end
  end

endmodule

// File: hdl/vertex_transform_project_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex transform, projection and shading
// Rotates, translates, projects and shades one vertex per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// The block takes one vertex every cycle while the output is not stalled and
// passes it through two stages of multiply and sum, one stage that prepares
// the divide, one restoring divider step per quotient bit for both screen
// axes at once, and the output register. A stall on the output holds the
// whole pipeline, so nothing is lost or repeated.
module vertex_transform_project_shade #(
  parameter int FRACTION_BITS    = 8,
  parameter int PROJECTION_SHIFT = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  config_write,
  input  logic [vtps_pkg::CFG_IDX_W-1:0]        config_index,
  input  logic [vtps_pkg::CFG_W-1:0]            config_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [vtps_pkg::COORD_W-1:0]   coord_x,
  input  logic signed [vtps_pkg::COORD_W-1:0]   coord_y,
  input  logic signed [vtps_pkg::COORD_W-1:0]   coord_z,
  input  logic signed [vtps_pkg::NORMAL_W-1:0]  normal_x,
  input  logic signed [vtps_pkg::NORMAL_W-1:0]  normal_y,
  input  logic signed [vtps_pkg::NORMAL_W-1:0]  normal_z,
  input  logic                                  last_vertex,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [vtps_pkg::SCREEN_W-1:0]  screen_x,
  output logic signed [vtps_pkg::SCREEN_W-1:0]  screen_y,
  output logic                                  projected,
  output logic signed [vtps_pkg::POS_W-1:0]     depth,
  output logic [vtps_pkg::SHADE_W-1:0]          shade,
  output logic                                  last_vertex_out
);

  localparam int PW   = vtps_pkg::POS_W;
  localparam int NUMW = PW + PROJECTION_SHIFT;
  localparam int SHW  = vtps_pkg::NRM_W + FRACTION_BITS;
  localparam int SUMW = NUMW + 2;

  logic [vtps_pkg::ROW_W-1:0]         row_x;
  logic [vtps_pkg::ROW_W-1:0]         row_y;
  logic [vtps_pkg::ROW_W-1:0]         row_z;
  logic signed [vtps_pkg::OFFS_W-1:0] off_x;
  logic signed [vtps_pkg::OFFS_W-1:0] off_y;
  logic signed [vtps_pkg::OFFS_W-1:0] off_z;
  logic [vtps_pkg::CENTER_W-1:0]      center;
  logic                               light;

  logic                               en;
  logic                               xv;
  logic signed [PW-1:0]               rx;
  logic signed [PW-1:0]               ry;
  logic signed [PW-1:0]               rz;
  logic signed [vtps_pkg::NRM_W-1:0]  rnz;
  logic                               xlast;

  logic [PW-1:0]                      mag_x;
  logic [PW-1:0]                      mag_y;
  logic signed [SHW-1:0]              sh_dyn;
  logic signed [vtps_pkg::NRM_W-1:0]  sh_sta;
  logic signed [SHW-1:0]              sh_val;
  logic [vtps_pkg::SHADE_W-1:0]       sh_clamp;
  vtps_pkg::side_t                    prep_side;

  logic                               dv   [NUMW+1];
  logic [PW-1:0]                      dd   [NUMW+1];
  logic [NUMW-1:0]                    dnx  [NUMW+1];
  logic [NUMW-1:0]                    dny  [NUMW+1];
  logic [PW-1:0]                      drx  [NUMW+1];
  logic [PW-1:0]                      dry  [NUMW+1];
  logic [NUMW-1:0]                    dqx  [NUMW+1];
  logic [NUMW-1:0]                    dqy  [NUMW+1];
  vtps_pkg::side_t                    dside[NUMW+1];

  vtps_pkg::side_t                    fs;
  logic signed [SUMW-1:0]             qx;
  logic signed [SUMW-1:0]             qy;
  logic signed [SUMW-1:0]             sum_x;
  logic signed [SUMW-1:0]             sum_y;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x  <= vtps_pkg::ROW_W'(256);
      row_y  <= vtps_pkg::ROW_W'(262144);
      row_z  <= vtps_pkg::ROW_W'(268435456);
      off_x  <= '0;
      off_y  <= '0;
      off_z  <= '0;
      center <= vtps_pkg::CENTER_W'(245920);
      light  <= 1'b0;
    end else if (config_write) begin
      case (vtps_pkg::cfg_reg_t'(config_index))
        vtps_pkg::REG_ROW_X:    row_x  <= config_data;
        vtps_pkg::REG_ROW_Y:    row_y  <= config_data;
        vtps_pkg::REG_ROW_Z:    row_z  <= config_data;
        vtps_pkg::REG_OFFSET_X: off_x  <= config_data[vtps_pkg::OFFS_W-1:0];
        vtps_pkg::REG_OFFSET_Y: off_y  <= config_data[vtps_pkg::OFFS_W-1:0];
        vtps_pkg::REG_OFFSET_Z: off_z  <= config_data[vtps_pkg::OFFS_W-1:0];
        vtps_pkg::REG_CENTER:   center <= config_data[vtps_pkg::CENTER_W-1:0];
        vtps_pkg::REG_LIGHT:    light  <= config_data[0];
        default: ;
      endcase
    end
  end

  vtps_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (in_valid),
    .cx        (coord_x),
    .cy        (coord_y),
    .cz        (coord_z),
    .nx        (normal_x),
    .ny        (normal_y),
    .nz        (normal_z),
    .last_in   (last_vertex),
    .row_x     (row_x),
    .row_y     (row_y),
    .row_z     (row_z),
    .off_x     (off_x),
    .off_y     (off_y),
    .off_z     (off_z),
    .valid_out (xv),
    .rx        (rx),
    .ry        (ry),
    .rz        (rz),
    .rnz       (rnz),
    .last_out  (xlast)
  );

  assign mag_x  = rx[PW-1] ? PW'(-rx) : PW'(rx);
  assign mag_y  = ry[PW-1] ? PW'(-ry) : PW'(ry);
  assign sh_dyn = SHW'(rnz) <<< FRACTION_BITS;
  assign sh_sta = rnz >>> FRACTION_BITS;
  assign sh_val = light ? sh_dyn : SHW'(sh_sta);

  always_comb begin
    if (sh_val < 0) begin
      sh_clamp = '0;
    end else if (sh_val > SHW'(255)) begin
      sh_clamp = '1;
    end else begin
      sh_clamp = sh_val[vtps_pkg::SHADE_W-1:0];
    end
  end

  always_comb begin
    prep_side.proj  = rz > 0;
    prep_side.depth = rz;
    prep_side.shade = sh_clamp;
    prep_side.last  = xlast;
    prep_side.neg_x = rx[PW-1];
    prep_side.neg_y = ry[PW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= xv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0]    <= rz;
      dnx[0]   <= {mag_x, {PROJECTION_SHIFT{1'b0}}};
      dny[0]   <= {mag_y, {PROJECTION_SHIFT{1'b0}}};
      drx[0]   <= '0;
      dry[0]   <= '0;
      dqx[0]   <= '0;
      dqy[0]   <= '0;
      dside[0] <= prep_side;
    end
  end

  for (genvar k = 0; k < NUMW; k++) begin : g_div
    vtps_div_step #(
      .NUM_W (NUMW),
      .STEP  (k)
    ) u_step (
      .clk         (clk),
      .rst         (rst),
      .en          (en),
      .valid_in    (dv[k]),
      .divisor_in  (dd[k]),
      .num_x_in    (dnx[k]),
      .num_y_in    (dny[k]),
      .rem_x_in    (drx[k]),
      .rem_y_in    (dry[k]),
      .quo_x_in    (dqx[k]),
      .quo_y_in    (dqy[k]),
      .side_in     (dside[k]),
      .valid_out   (dv[k+1]),
      .divisor_out (dd[k+1]),
      .num_x_out   (dnx[k+1]),
      .num_y_out   (dny[k+1]),
      .rem_x_out   (drx[k+1]),
      .rem_y_out   (dry[k+1]),
      .quo_x_out   (dqx[k+1]),
      .quo_y_out   (dqy[k+1]),
      .side_out    (dside[k+1])
    );
  end

  assign fs    = dside[NUMW];
  assign qx    = fs.neg_x ? -SUMW'(dqx[NUMW]) : SUMW'(dqx[NUMW]);
  assign qy    = fs.neg_y ? -SUMW'(dqy[NUMW]) : SUMW'(dqy[NUMW]);
  assign sum_x = qx + SUMW'(center[vtps_pkg::HALF_W-1:0]);
  assign sum_y = qy + SUMW'(center[vtps_pkg::CENTER_W-1:vtps_pkg::HALF_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[NUMW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      screen_x        <= fs.proj ? vtps_pkg::SCREEN_W'(64'(sum_x)) : '0;
      screen_y        <= fs.proj ? vtps_pkg::SCREEN_W'(64'(sum_y)) : '0;
      projected       <= fs.proj;
      depth           <= fs.depth;
      shade           <= fs.shade;
      last_vertex_out <= fs.last;
    end
  end

  a_stall_ties: assert property (@(posedge clk) in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output stall");

  a_proj_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && projected |-> !depth[PW-1] && depth != '0)
    else $error("projected item without positive depth");

  a_unproj_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !projected |-> screen_x == '0 && screen_y == '0)
    else $error("unprojected item with nonzero screen position");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(dv[NUMW]) && $stable(dv[0]))
    else $error("pipeline advanced while stalled");

endmodule
